@@ hw/rtl/pid_pkg.sv @@
// Shared constants, codes and types of the positional insert deque.
`default_nettype none
package pid_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int ID_WIDTH_DEF = 16;

  // Port widths of the request and result fields.
  localparam int REQ_W    = 2;
  localparam int ITEM_W   = 16;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_INSERT_AT  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CLAMPED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the incoming request
    logic exec;  // carry out the held request and register its result
  } pid_cmd_t;

endpackage
`default_nettype wire

@@ hw/rtl/positional_insert_deque.sv @@
// Top level of the positional insert deque: controller, datapath and checks.
//
// An ordered queue of up to DEPTH identifiers held in a chain of cells packed from
// the front. A request inserts at the front, at the back or at a 1-based position,
// or removes the front entry; every request gives one result carrying the status,
// the removed identifier, the new head and tail and the entry count. A request is
// captured in a request register and carried out in the next cycle in which the
// output register is free, which then registers its result, and one request per
// cycle is sustained while the result side does not stall. A result passes the
// request register and the output register; every cell compares its index with
// the insert position in parallel and all cells shift together.
// Identifiers are kept to ID_WIDTH bits. The entry count port is five bits wide.
`default_nettype none
module positional_insert_deque
  import pid_pkg::*;
#(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int ID_WIDTH = ID_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [REQ_W-1:0]    in_req_type,
  input  wire logic [ITEM_W-1:0]   in_item_id,
  input  wire logic [POS_W-1:0]    in_position,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic      [STATUS_W-1:0] out_status,
  output logic      [ITEM_W-1:0]   out_removed_id,
  output logic      [ITEM_W-1:0]   out_head_id,
  output logic      [ITEM_W-1:0]   out_tail_id,
  output logic      [COUNT_W-1:0]  out_entry_count
);

  pid_cmd_t cmd;

  pid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  pid_datapath #(
    .DEPTH    (DEPTH),
    .ID_WIDTH (ID_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_req_type     (in_req_type),
    .in_item_id      (in_item_id),
    .in_position     (in_position),
    .out_status      (out_status),
    .out_removed_id  (out_removed_id),
    .out_head_id     (out_head_id),
    .out_tail_id     (out_tail_id),
    .out_entry_count (out_entry_count)
  );

  // A request is only carried out once the output register can take its result.
  a_exec_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> (!out_valid || !out_stall))
    else $error("request executed while the result register was blocked");

  // A removal from an empty queue leaves it empty and removes nothing.
  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (out_entry_count == '0 && out_removed_id == '0))
    else $error("removal on empty reported a removed identifier or entries");

  // An empty queue reports zero at both ends.
  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_entry_count == '0) |-> (out_head_id == '0 && out_tail_id == '0))
    else $error("empty queue reported a non-zero head or tail");

  // A dropped insert removes nothing.
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_removed_id == '0))
    else $error("dropped insert reported a removed identifier");

endmodule
`default_nettype wire

@@ hw/rtl/pid_ctrl.sv @@
// Controller: request holding state, result valid and the two stalls.
`default_nettype none
module pid_ctrl
  import pid_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  output pid_cmd_t  cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HELD = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;
  logic exec;
  logic accept;

  always_comb begin
    out_free = !out_valid_r || !out_stall;
    exec     = 1'b0;
    case (state_r)
      S_IDLE:  exec = 1'b0;
      S_HELD:  exec = out_free;
      default: exec = 1'b0;
    endcase
    // A held request blocks the input until it has moved into the output register.
    // No request is taken while reset is applied.
    in_stall      = !rst_n || ((state_r == S_HELD) && !exec);
    accept        = in_valid && !in_stall;
    state_nxt     = accept ? S_HELD : (exec ? S_IDLE : state_r);
    out_valid_nxt = exec || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign cmd.load  = accept;
  assign cmd.exec  = exec;

endmodule
`default_nettype wire

@@ hw/rtl/pid_datapath.sv @@
// Datapath: request register, chain of identifier cells, occupancy and result registers.
`default_nettype none
module pid_datapath
  import pid_pkg::*;
#(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int ID_WIDTH = ID_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire pid_cmd_t            cmd,
  input  wire logic [REQ_W-1:0]    in_req_type,
  input  wire logic [ITEM_W-1:0]   in_item_id,
  input  wire logic [POS_W-1:0]    in_position,
  output logic      [STATUS_W-1:0] out_status,
  output logic      [ITEM_W-1:0]   out_removed_id,
  output logic      [ITEM_W-1:0]   out_head_id,
  output logic      [ITEM_W-1:0]   out_tail_id,
  output logic      [COUNT_W-1:0]  out_entry_count
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [REQ_W-1:0]    req_r;
  logic [ID_WIDTH-1:0] id_r;
  logic [POS_W-1:0]    pos_r;

  logic [ID_WIDTH-1:0] cells_r   [DEPTH];
  logic [ID_WIDTH-1:0] cells_nxt [DEPTH];
  logic [ID_WIDTH-1:0] ins_val   [DEPTH];
  logic [ID_WIDTH-1:0] rem_val   [DEPTH];
  logic [CW-1:0]       count_r, count_nxt;
  logic [ID_WIDTH-1:0] tail_r, tail_nxt;

  logic [STATUS_W-1:0] status_nxt;
  logic [ID_WIDTH-1:0] removed_nxt;
  logic [CW-1:0]       ins_idx;
  logic                do_insert;
  logic                do_remove;
  logic                full;
  logic [CMPW-1:0]     pos_w;
  logic [CMPW-1:0]     count_w;

  // Each cell picks its new value from its own index compared with the insert index.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign ins_val[g] = (ins_idx == CW'(g)) ? id_r : cells_r[g];
    end else begin : g_rest
      assign ins_val[g] = (CW'(g) < ins_idx)  ? cells_r[g] :
                          (CW'(g) == ins_idx) ? id_r : cells_r[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign rem_val[g] = cells_r[g];
    end else begin : g_inner
      assign rem_val[g] = cells_r[g+1];
    end
  end

  always_comb begin
    full        = (count_r == CW'(DEPTH));
    pos_w       = CMPW'(pos_r);
    count_w     = CMPW'(count_r);
    status_nxt  = ST_OK;
    removed_nxt = '0;
    ins_idx     = count_r;
    do_insert   = 1'b0;
    do_remove   = 1'b0;
    case (req_r)
      REQ_POP_FRONT: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          do_remove   = 1'b1;
          removed_nxt = cells_r[0];
        end
      end
      REQ_PUSH_FRONT: begin
        ins_idx   = '0;
        do_insert = !full;
      end
      REQ_PUSH_BACK: begin
        ins_idx   = count_r;
        do_insert = !full;
      end
      REQ_INSERT_AT: begin
        do_insert = !full;
        if (pos_w <= CMPW'(1)) begin
          ins_idx = '0;
        end else if (pos_w > count_w + CMPW'(1)) begin
          ins_idx    = count_r;
          status_nxt = ST_CLAMPED;
        end else begin
          ins_idx = CW'(pos_w - CMPW'(1));
        end
      end
      default: begin
        do_insert = 1'b0;
      end
    endcase
    // A full queue overrides clamping.
    if (req_r != REQ_POP_FRONT && full) begin
      status_nxt = ST_FULL;
    end

    count_nxt = count_r;
    tail_nxt  = tail_r;
    for (int i = 0; i < DEPTH; i++) begin
      cells_nxt[i] = cells_r[i];
    end
    if (do_insert) begin
      count_nxt = count_r + CW'(1);
      if (ins_idx == count_r) begin
        tail_nxt = id_r;
      end
      for (int i = 0; i < DEPTH; i++) begin
        cells_nxt[i] = ins_val[i];
      end
    end else if (do_remove) begin
      count_nxt = count_r - CW'(1);
      for (int i = 0; i < DEPTH; i++) begin
        cells_nxt[i] = rem_val[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req_type;
      id_r  <= ID_WIDTH'(in_item_id);
      pos_r <= in_position;
    end
    if (cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        cells_r[i] <= cells_nxt[i];
      end
      tail_r          <= tail_nxt;
      out_status      <= status_nxt;
      out_removed_id  <= ITEM_W'(removed_nxt);
      out_head_id     <= (count_nxt == '0) ? '0 : ITEM_W'(cells_nxt[0]);
      out_tail_id     <= (count_nxt == '0) ? '0 : ITEM_W'(tail_nxt);
      out_entry_count <= COUNT_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire
